// File: hw/rtl/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg: shared types and constants of the button click classifier
// Holds the register map, the configuration bundle and the classifier
// decision bundle used by the evaluation logic and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package bcc_pkg;

	// configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HIGH     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EMIT_ON_RELEASE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_ENABLE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_ENABLE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_MAX      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 3'd7;

	// event kinds
	localparam logic KIND_CLICK  = 1'b0;
	localparam logic KIND_DOUBLE = 1'b1;

	// register reset values
	localparam logic [9:0]  DEBOUNCE_RST        = 10'd20;
	localparam logic [11:0] DOUBLE_MAX_RST      = 12'd300;
	localparam logic [11:0] REPEAT_DELAY_RST    = 12'd300;
	localparam logic [11:0] REPEAT_INTERVAL_RST = 12'd100;

	typedef struct packed {
		logic        active_high;
		logic        emit_on_release;
		logic        repeat_enable;
		logic        double_click_enable;
		logic [9:0]  debounce_ms;
		logic [11:0] double_click_max_ms;
		logic [11:0] repeat_delay_ms;
		logic [11:0] repeat_interval_ms;
	} bcc_cfg_t;

	// decision for one poll: event and next flags
	typedef struct packed {
		logic emit;
		logic kind;
		logic pending;
		logic repeat_flag;
	} bcc_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/button_click_classifier_core.sv
// A poll passes through the input register and then the result register before its click event is presented.
// Throughput: one poll per cycle while the result side does not stall; each poll causes at most one event.
// The input register advances whenever the result register is empty or taken.
// Reset: registers return to their default values, previous level reads as 1,
// time count and click flags clear, no result is held.
// ----------------------------------------------------------------------------
// button_click_classifier_core: button click and double-click classifier
// Input register, single-pass classifier logic with state feedback and an
// output register that decouples the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module button_click_classifier_core #(
	parameter int REPEAT_MAX_MS = 1000,
	parameter int TIME_WIDTH    = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// configuration
	input  wire                          cfg_we,
	input  wire [bcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [bcc_pkg::CFG_DATA_W-1:0] cfg_data,
	// polls
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire                          button_level,
	input  wire [9:0]                    elapsed_ms,
	// events
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic                         event_kind,
	output logic                         last_of_run
);
	import bcc_pkg::*;

	bcc_cfg_t              cfg_q;
	logic                  valid_s1;
	logic                  level_s1;
	logic [9:0]            elapsed_s1;
	logic                  prev_level_q;
	logic [TIME_WIDTH-1:0] ms_since_q;
	logic                  pending_q;
	logic                  repeat_q;
	logic                  out_valid_q;
	logic                  kind_q;
	logic                  advance;
	bcc_res_t              res;
	logic [TIME_WIDTH-1:0] ms_next;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_high         <= 1'b1;
			cfg_q.emit_on_release     <= 1'b1;
			cfg_q.repeat_enable       <= 1'b0;
			cfg_q.double_click_enable <= 1'b0;
			cfg_q.debounce_ms         <= DEBOUNCE_RST;
			cfg_q.double_click_max_ms <= DOUBLE_MAX_RST;
			cfg_q.repeat_delay_ms     <= REPEAT_DELAY_RST;
			cfg_q.repeat_interval_ms  <= REPEAT_INTERVAL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ACTIVE_HIGH:     cfg_q.active_high         <= cfg_data[0];
				REG_EMIT_ON_RELEASE: cfg_q.emit_on_release     <= cfg_data[0];
				REG_REPEAT_ENABLE:   cfg_q.repeat_enable       <= cfg_data[0];
				REG_DOUBLE_ENABLE:   cfg_q.double_click_enable <= cfg_data[0];
				REG_DEBOUNCE:        cfg_q.debounce_ms         <= cfg_data[9:0];
				REG_DOUBLE_MAX:      cfg_q.double_click_max_ms <= cfg_data[11:0];
				REG_REPEAT_DELAY:    cfg_q.repeat_delay_ms     <= cfg_data[11:0];
				REG_REPEAT_INTERVAL: cfg_q.repeat_interval_ms  <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// advance when the result register is free or being taken
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	// capture the poll
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			level_s1   <= button_level;
			elapsed_s1 <= elapsed_ms;
		end
	end

	bcc_eval #(
		.REPEAT_MAX_MS (REPEAT_MAX_MS),
		.TIME_WIDTH    (TIME_WIDTH)
	) u_eval (
		.cfg         (cfg_q),
		.level       (level_s1),
		.elapsed     (elapsed_s1),
		.prev_level  (prev_level_q),
		.ms_since    (ms_since_q),
		.pending     (pending_q),
		.repeat_flag (repeat_q),
		.res         (res),
		.ms_next     (ms_next)
	);

	// update classifier state once per transfer through the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q <= 1'b1;
			ms_since_q   <= '0;
			pending_q    <= 1'b0;
			repeat_q     <= 1'b0;
		end else if (valid_s1 && advance) begin
			prev_level_q <= level_s1;
			ms_since_q   <= ms_next;
			pending_q    <= res.pending;
			repeat_q     <= res.repeat_flag;
		end
	end

	// load or drain the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_q <= res.kind;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_kind  = kind_q;
	// every event is the only one of its poll
	assign last_of_run = 1'b1;

	// a double click needs double-click detection switched on
	a_double_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == KIND_DOUBLE |-> cfg_q.double_click_enable)
		else $error("double click with detection disabled");

	// input is held back only while a poll waits in the input register
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	// a stalled poll leaves classifier state untouched
	a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(ms_since_q) && $stable(prev_level_q))
		else $error("state changed while poll stalled");

	// a repeat flag only arises from an emitted repeat click
	a_repeat_sets_with_event: assert property (@(posedge clk) disable iff (!arst_n)
		!repeat_q ##1 repeat_q |-> out_valid)
		else $error("repeat flag set without an event");

endmodule

`default_nettype wire

// File: hw/rtl/bcc_eval.sv
// ----------------------------------------------------------------------------
// bcc_eval: per-poll classifier decision
// Saturating time update, edge detection and the ordered rules: pending
// timeout, trigger edge, auto repeat. Purely combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module bcc_eval #(
	parameter int REPEAT_MAX_MS = 1000,
	parameter int TIME_WIDTH    = 16
) (
	input  var bcc_pkg::bcc_cfg_t   cfg,
	input  wire                     level,
	input  wire [9:0]               elapsed,
	input  wire                     prev_level,
	input  wire [TIME_WIDTH-1:0]    ms_since,
	input  wire                     pending,
	input  wire                     repeat_flag,
	output bcc_pkg::bcc_res_t       res,
	output logic [TIME_WIDTH-1:0]   ms_next
);
	import bcc_pkg::*;

	localparam int CMP_W = (TIME_WIDTH > 17) ? TIME_WIDTH : 17;

	logic [TIME_WIDTH:0]   sum;
	logic [TIME_WIDTH-1:0] t;
	logic [CMP_W-1:0]      tc;
	logic press_edge, release_edge, trig, other, held;
	logic gt_dmax, gt_deb, gt_delay, gt_intv, lt_rmax;

	// add the elapsed time, saturating at all ones
	assign sum = {1'b0, ms_since} + (TIME_WIDTH+1)'(elapsed);
	assign t   = sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : sum[TIME_WIDTH-1:0];
	assign tc  = CMP_W'(t);

	// threshold compares
	assign gt_dmax  = tc > CMP_W'(cfg.double_click_max_ms);
	assign gt_deb   = tc > CMP_W'(cfg.debounce_ms);
	assign gt_delay = tc > CMP_W'(cfg.repeat_delay_ms);
	assign gt_intv  = tc > CMP_W'(cfg.repeat_interval_ms);
	assign lt_rmax  = tc < CMP_W'(REPEAT_MAX_MS);

	// edges relative to the pressed level
	assign press_edge   = (level == cfg.active_high) && (prev_level != cfg.active_high);
	assign release_edge = (level != cfg.active_high) && (prev_level == cfg.active_high);
	assign trig  = cfg.emit_on_release ? release_edge : press_edge;
	assign other = cfg.emit_on_release ? press_edge : release_edge;
	assign held  = (level == cfg.active_high) && (prev_level == cfg.active_high);

	// apply the rules in order; a pending click past the gap is always
	// resolved by the timeout rule, so a poll causes at most one event
	always_comb begin
		res.emit        = 1'b0;
		res.kind        = KIND_CLICK;
		res.pending     = pending;
		res.repeat_flag = repeat_flag;
		ms_next         = t;
		if (cfg.double_click_enable && pending && gt_dmax) begin
			res.emit    = 1'b1;
			res.pending = 1'b0;
		end else if (trig && gt_deb) begin
			if (!repeat_flag) begin
				if (cfg.double_click_enable && pending) begin
					res.emit    = 1'b1;
					res.kind    = KIND_DOUBLE;
					res.pending = 1'b0;
				end else if (cfg.double_click_enable) begin
					res.pending = 1'b1;
				end else begin
					res.emit    = 1'b1;
					res.pending = 1'b0;
				end
			end
			ms_next         = '0;
			res.repeat_flag = 1'b0;
		end else if (cfg.repeat_enable &&
		             ((!repeat_flag && gt_delay) || (repeat_flag && gt_intv))) begin
			if (other) begin
				ms_next = '0;
			end else if (held && lt_rmax) begin
				ms_next         = '0;
				res.emit        = 1'b1;
				res.pending     = 1'b0;
				res.repeat_flag = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: tb/button_click_classifier_core_test.sv
// ----------------------------------------------------------------------------
// button_click_classifier_core_test: self-checking bench for the click classifier
// Drives button polls with bursty timing against a randomly stalling event
// receiver. A behavioural classifier predicts every click and double click.
// Each observed event is checked in order against the prediction.
// Directed cases come first, then a receiver hold-off that fills the pipe,
// then randomised register settings with mostly well-formed press/release
// trains.
// ----------------------------------------------------------------------------
module button_click_classifier_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bcc_pkg::*;

	localparam int REPEAT_MAX_MS  = 1000;
	localparam int TIME_WIDTH     = 16;
	localparam int DRAIN_CYCLES   = 8;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASES         = 7;
	localparam int PHASE_ITEMS    = 235;

	typedef struct packed {
		logic kind;
		logic last;
	} click_event_t;

	// block ports
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  button_level = 1'b0;
	logic [9:0]            elapsed_ms = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  event_kind;
	logic                  last_of_run;

	// predicted classifier state and registers
	bcc_cfg_t              cfg_model;
	logic                  prev_level = 1'b1;
	logic [TIME_WIDTH-1:0] ms_count = '0;
	logic                  held_click = 1'b0;
	logic                  repeat_active = 1'b0;
	click_event_t          click_queue[$];

	int mismatch_count = 0;
	int burst_left = 0;
	bit gaps_enabled = 1'b1;
	bit hold_request = 1'b0;
	int hold_left = 0;
	int stall_mode = 0;
	int stall_mode_left = 0;
	int quiet_cycles = 0;

	button_click_classifier_core #(
		.REPEAT_MAX_MS(REPEAT_MAX_MS),
		.TIME_WIDTH   (TIME_WIDTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.button_level(button_level),
		.elapsed_ms  (elapsed_ms),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.event_kind  (event_kind),
		.last_of_run (last_of_run)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Classify one accepted poll and queue the events it raises
	task automatic classify_poll(input logic level, input logic [9:0] ms);
		logic                  act, old, press_e, release_e, trig, other;
		logic [TIME_WIDTH:0]   sum;
		logic [TIME_WIDTH-1:0] t;
		logic                  kinds[2];
		int                    n;
		click_event_t          ev;
		n = 0;
		act = cfg_model.active_high;
		old = prev_level;
		press_e = (level == act) && (old != act);
		release_e = (level != act) && (old == act);
		trig = cfg_model.emit_on_release ? release_e : press_e;
		other = cfg_model.emit_on_release ? press_e : release_e;

		// saturating time count
		sum = {1'b0, ms_count} + (TIME_WIDTH+1)'(ms);
		t = sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : sum[TIME_WIDTH-1:0];
		ms_count = t;

		if (cfg_model.double_click_enable && held_click &&
		    t > cfg_model.double_click_max_ms) begin
			// pending click timed out
			kinds[n] = KIND_CLICK;
			n++;
			held_click = 1'b0;
		end else if (trig && t > cfg_model.debounce_ms) begin
			if (!repeat_active) begin
				if (cfg_model.double_click_enable && held_click) begin
					if (t <= cfg_model.double_click_max_ms) begin
						kinds[n] = KIND_DOUBLE;
						n++;
					end else begin
						kinds[0] = KIND_CLICK;
						kinds[1] = KIND_CLICK;
						n = 2;
					end
					held_click = 1'b0;
				end else if (cfg_model.double_click_enable) begin
					held_click = 1'b1;
				end else begin
					kinds[n] = KIND_CLICK;
					n++;
					held_click = 1'b0;
				end
			end
			ms_count = '0;
			repeat_active = 1'b0;
		end else if (cfg_model.repeat_enable &&
		             ((!repeat_active && t > cfg_model.repeat_delay_ms) ||
		              (repeat_active && t > cfg_model.repeat_interval_ms))) begin
			if (other) begin
				ms_count = '0;
			end else if (level == act && old == act && t < REPEAT_MAX_MS) begin
				// auto-repeat while held
				ms_count = '0;
				kinds[n] = KIND_CLICK;
				n++;
				held_click = 1'b0;
				repeat_active = 1'b1;
			end
		end

		prev_level = level;
		for (int i = 0; i < n; i++) begin
			ev.kind = kinds[i];
			ev.last = (i == n - 1);
			click_queue = {click_queue, ev};
		end
	endtask

	// Offer one poll, idling between bursts, and hold it until transferred
	task automatic send_poll(input logic level, input logic [9:0] ms);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = 0;
			if (gaps_enabled && $urandom_range(0, 2) != 0)
				gap = $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		button_level <= level;
		elapsed_ms <= ms;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		classify_poll(level, ms);
	endtask

	// Stop offering and wait until the block has gone quiet
	task automatic settle_block();
		in_valid <= 1'b0;
		while (click_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write every register while the block is idle
	task automatic load_config(input bcc_cfg_t c);
		logic [CFG_DATA_W-1:0] value;
		logic [CFG_IDX_W-1:0]  idx;
		settle_block();
		for (int i = 0; i < 8; i++) begin
			idx = i[CFG_IDX_W-1:0];
			value = '0;
			case (idx)
				REG_ACTIVE_HIGH:     value[0] = c.active_high;
				REG_EMIT_ON_RELEASE: value[0] = c.emit_on_release;
				REG_REPEAT_ENABLE:   value[0] = c.repeat_enable;
				REG_DOUBLE_ENABLE:   value[0] = c.double_click_enable;
				REG_DEBOUNCE:        value[9:0] = c.debounce_ms;
				REG_DOUBLE_MAX:      value = c.double_click_max_ms;
				REG_REPEAT_DELAY:    value = c.repeat_delay_ms;
				REG_REPEAT_INTERVAL: value = c.repeat_interval_ms;
				default:             value = '0;
			endcase
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_data <= value;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cfg_model = c;
	endtask

	// Pick a poll interval, biased towards the current thresholds
	function automatic logic [9:0] pick_gap_ms();
		int v;
		case ($urandom_range(0, 7))
			0:       v = $urandom_range(0, 1023);
			1:       v = $urandom_range(0, 3);
			2:       v = int'(cfg_model.debounce_ms) + int'($urandom_range(0, 4)) - 2;
			3:       v = int'(cfg_model.double_click_max_ms) / 2
			             + int'($urandom_range(0, 4)) - 2;
			4:       v = int'(cfg_model.repeat_interval_ms) + int'($urandom_range(0, 4)) - 2;
			5:       v = int'(cfg_model.repeat_delay_ms) / 2 + int'($urandom_range(0, 4)) - 2;
			6:       v = $urandom_range(10, 60);
			default: v = $urandom_range(100, 400);
		endcase
		if (v < 0)
			v = 0;
		if (v > 1023)
			v = 1023;
		return v[9:0];
	endfunction

	// Random register set; phase 1 takes every maximum, phase 2 every zero
	function automatic bcc_cfg_t random_config(input int phase);
		bcc_cfg_t c;
		c.active_high = 1'($urandom_range(0, 1));
		c.emit_on_release = 1'($urandom_range(0, 1));
		c.repeat_enable = 1'($urandom_range(0, 1));
		c.double_click_enable = 1'($urandom_range(0, 1));
		c.debounce_ms = ($urandom_range(0, 7) == 0) ? 10'd1023 : 10'($urandom_range(0, 60));
		c.double_click_max_ms = ($urandom_range(0, 7) == 0) ? 12'd4095
		                        : 12'($urandom_range(0, 600));
		c.repeat_delay_ms = ($urandom_range(0, 7) == 0) ? 12'd4095
		                    : 12'($urandom_range(0, 500));
		c.repeat_interval_ms = ($urandom_range(0, 7) == 0) ? 12'd4095
		                       : 12'($urandom_range(0, 300));
		if (phase == 1) begin
			c.debounce_ms = 10'd1023;
			c.double_click_max_ms = 12'd4095;
			c.repeat_delay_ms = 12'd4095;
			c.repeat_interval_ms = 12'd4095;
		end else if (phase == 2) begin
			c.debounce_ms = '0;
			c.double_click_max_ms = '0;
			c.repeat_delay_ms = '0;
			c.repeat_interval_ms = '0;
		end
		return c;
	endfunction

	// Reset register values: release-edge clicks, debounce and field extremes
	task automatic test_single_click();
		send_poll(1'b0, 10'd30);
		send_poll(1'b1, 10'd5);
		send_poll(1'b0, 10'd10);
		send_poll(1'b1, 10'd1023);
		send_poll(1'b0, 10'd1023);
		send_poll(1'b0, 10'd0);
	endtask

	// Press-edge double click, zero debounce and pending timeout
	task automatic test_double_click();
		load_config('{active_high: 1'b1, emit_on_release: 1'b0, repeat_enable: 1'b0,
		              double_click_enable: 1'b1, debounce_ms: 10'd0,
		              double_click_max_ms: 12'd300, repeat_delay_ms: 12'd300,
		              repeat_interval_ms: 12'd100});
		send_poll(1'b1, 10'd1);
		send_poll(1'b0, 10'd50);
		send_poll(1'b1, 10'd50);
		send_poll(1'b0, 10'd1);
		send_poll(1'b1, 10'd0);
		send_poll(1'b0, 10'd1023);
	endtask

	// Active-low auto-repeat: delay, interval, opposite edge, repeat ending
	task automatic test_auto_repeat();
		load_config('{active_high: 1'b0, emit_on_release: 1'b1, repeat_enable: 1'b1,
		              double_click_enable: 1'b0, debounce_ms: 10'd20,
		              double_click_max_ms: 12'd300, repeat_delay_ms: 12'd300,
		              repeat_interval_ms: 12'd100});
		send_poll(1'b0, 10'd200);
		send_poll(1'b0, 10'd150);
		send_poll(1'b0, 10'd110);
		send_poll(1'b0, 10'd110);
		send_poll(1'b1, 10'd20);
		send_poll(1'b0, 10'd200);
		send_poll(1'b0, 10'd700);
		send_poll(1'b0, 10'd1023);
		send_poll(1'b1, 10'd30);
	endtask

	// Hold the receiver off while clicks keep arriving back to back
	task automatic test_backpressure();
		load_config('{active_high: 1'b1, emit_on_release: 1'b1, repeat_enable: 1'b0,
		              double_click_enable: 1'b0, debounce_ms: 10'd20,
		              double_click_max_ms: 12'd300, repeat_delay_ms: 12'd300,
		              repeat_interval_ms: 12'd100});
		gaps_enabled = 1'b0;
		hold_request = 1'b1;
		repeat (40) begin
			send_poll(1'b1, 10'd30);
			send_poll(1'b0, 10'd30);
		end
		gaps_enabled = 1'b1;
	endtask

	// Random settings with press/release trains, holds, long idles and noise
	task automatic test_random_phases();
		int   sent;
		int   pick;
		int   len;
		logic pressed;
		logic lvl;
		for (int phase = 0; phase < PHASES; phase++) begin
			load_config(random_config(phase));
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				pressed = cfg_model.active_high;
				pick = $urandom_range(0, 59);
				if (pick < 30) begin
					len = $urandom_range(1, 6);
					repeat (len) begin
						send_poll(pressed, pick_gap_ms());
						send_poll(!pressed, pick_gap_ms());
					end
					sent += 2 * len;
				end else if (pick < 45) begin
					len = $urandom_range(2, 12);
					repeat (len) send_poll(pressed, pick_gap_ms());
					sent += len;
				end else if (pick == 59) begin
					// long steady level: drive the time count into saturation
					lvl = 1'($urandom_range(0, 1));
					repeat (80) send_poll(lvl, 10'($urandom_range(850, 1023)));
					sent += 80;
				end else begin
					len = $urandom_range(1, 8);
					repeat (len)
						send_poll(1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)));
					sent += len;
				end
			end
		end
	endtask

	// Receiver stall: long hold-off on request, otherwise a shifting pattern
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			if (stall_mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_mode_left = $urandom_range(16, 128);
			end
			stall_mode_left--;
			case (stall_mode)
				0:       out_stall <= 1'b0;
				1:       out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// Check each event transfer against the oldest prediction
	always @(posedge clk) begin
		click_event_t exp_event;
		if (arst_n && out_valid && !out_stall) begin
			if (click_queue.size() == 0) begin
				report_mismatch($sformatf("unexpected event kind=%0b last=%0b",
				                          event_kind, last_of_run));
			end else begin
				exp_event = click_queue.pop_front();
				if (event_kind !== exp_event.kind)
					report_mismatch($sformatf("event_kind %0b, expected %0b",
					                          event_kind, exp_event.kind));
				if (last_of_run !== exp_event.last)
					report_mismatch($sformatf("last_of_run %0b, expected %0b",
					                          last_of_run, exp_event.last));
			end
		end
	end

	// Abort when nothing has transferred for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("[%0t] watchdog: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		cfg_model = '{active_high: 1'b1, emit_on_release: 1'b1, repeat_enable: 1'b0,
		              double_click_enable: 1'b0, debounce_ms: DEBOUNCE_RST,
		              double_click_max_ms: DOUBLE_MAX_RST,
		              repeat_delay_ms: REPEAT_DELAY_RST,
		              repeat_interval_ms: REPEAT_INTERVAL_RST};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_click();
		test_double_click();
		test_auto_repeat();
		test_backpressure();
		test_random_phases();

		settle_block();
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
